// File: rtl/lrosm_pkg.sv
// Shared types and constants for the lidar row outlier repair block.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package lrosm_pkg;

	localparam int SPEED_W   = 24;
	localparam int SNR_W     = 16;
	localparam int THR_W     = 23;
	localparam int GATE_W    = 6;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_W     = THR_W;

	// register indexes on the configuration port
	localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SNR_LEVEL = 1'd1;

	localparam logic [THR_W-1:0] THRESHOLD_RESET = 23'd1280;
	localparam logic [SNR_W-1:0] SNR_LEVEL_RESET = 16'd0;

	// result queue: one gate can release two words
	localparam int QDEPTH = 4;
	localparam int QPTR_W = 2;
	localparam int QCNT_W = 3;

	typedef struct packed {
		logic signed [SPEED_W-1:0] speed_sample;
		logic                      speed_valid;
		logic signed [SNR_W-1:0]   snr_sample;
		logic                      snr_valid;
		logic                      row_end;
	} in_t;

	typedef struct packed {
		logic signed [SPEED_W-1:0] speed_out;
		logic                      speed_out_valid;
		logic [GATE_W-1:0]         gate_index;
		logic                      row_done;
		logic                      mask_found;
		logic [GATE_W-1:0]         mask_gate;
	} out_t;

	// words produced for one accepted gate
	typedef struct packed {
		logic push_held;
		logic push_last;
	} push_t;

	typedef struct packed {
		logic              room;
		logic [QCNT_W-1:0] count;
	} q_stat_t;

endpackage

// File: rtl/lrosm_core.sv
// Row state, configuration registers and the neighbor average repair logic.
// Depends on lrosm_pkg.
`timescale 1ns / 1ps

module lrosm_core
	import lrosm_pkg::*;
#(
	parameter int MAX_GATES = 64
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	input  logic                 take,
	input  in_t                  in_word,
	output push_t                push,
	output out_t                 held_word,
	output out_t                 last_word
);

	localparam int LIM_INT = (MAX_GATES - 1 > 63) ? 63 : MAX_GATES - 1;
	localparam logic [GATE_W-1:0] GATE_LIM = GATE_W'(LIM_INT);

	logic [THR_W-1:0]          threshold_q;
	logic signed [SNR_W-1:0]   snr_level_q;
	logic signed [SPEED_W-1:0] held_speed_q;
	logic                      held_valid_q;
	logic signed [SPEED_W-1:0] left_speed_q;
	logic                      left_valid_q;
	logic [GATE_W-1:0]         gate_count_q;
	logic                      mask_hit_q;
	logic [GATE_W-1:0]         mask_pos_q;
	logic                      row_open_q;

	logic signed [SPEED_W-1:0] spd;
	logic [GATE_W-1:0]         ci;
	logic                      hit_now;
	logic                      hit_new;
	logic [GATE_W-1:0]         pos_new;
	logic signed [SPEED_W:0]   sum;
	logic signed [SPEED_W-1:0] avg;
	logic signed [SPEED_W:0]   diff;
	logic [SPEED_W:0]          adiff;
	logic                      repair;
	logic signed [SPEED_W-1:0] res;

	always_comb begin
		spd = in_word.speed_valid ? in_word.speed_sample : '0;
		if (!row_open_q) begin
			ci = '0;
		end else if (gate_count_q >= GATE_LIM) begin
			ci = GATE_LIM;
		end else begin
			ci = gate_count_q + GATE_W'(1);
		end

		hit_now = in_word.snr_valid && (in_word.snr_sample < snr_level_q) && !mask_hit_q;
		hit_new = mask_hit_q || hit_now;
		pos_new = hit_now ? ci : mask_pos_q;

		// sum >>> 1 floors toward minus infinity
		sum   = {left_speed_q[SPEED_W-1], left_speed_q} + {spd[SPEED_W-1], spd};
		avg   = sum[SPEED_W:1];
		diff  = {held_speed_q[SPEED_W-1], held_speed_q} - {avg[SPEED_W-1], avg};
		adiff = diff[SPEED_W] ? (SPEED_W+1)'(0) - diff : diff;
		repair = (gate_count_q != '0) && held_valid_q && left_valid_q && in_word.speed_valid
			&& (adiff > {2'b00, threshold_q});
		res = repair ? avg : held_speed_q;

		push.push_held = row_open_q;
		push.push_last = in_word.row_end;

		held_word.speed_out       = held_valid_q ? res : '0;
		held_word.speed_out_valid = held_valid_q;
		held_word.gate_index      = gate_count_q;
		held_word.row_done        = 1'b0;
		held_word.mask_found      = 1'b0;
		held_word.mask_gate       = '0;

		last_word.speed_out       = spd;
		last_word.speed_out_valid = in_word.speed_valid;
		last_word.gate_index      = ci;
		last_word.row_done        = 1'b1;
		last_word.mask_found      = hit_new;
		last_word.mask_gate       = hit_new ? pos_new : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q  <= THRESHOLD_RESET;
			snr_level_q  <= SNR_LEVEL_RESET;
			held_speed_q <= '0;
			held_valid_q <= 1'b0;
			left_speed_q <= '0;
			left_valid_q <= 1'b0;
			gate_count_q <= '0;
			mask_hit_q   <= 1'b0;
			mask_pos_q   <= '0;
			row_open_q   <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_THRESHOLD: threshold_q <= cfg_data;
					CFG_SNR_LEVEL: snr_level_q <= cfg_data[SNR_W-1:0];
					default: ;
				endcase
			end
			if (take) begin
				if (in_word.row_end) begin
					held_speed_q <= '0;
					held_valid_q <= 1'b0;
					left_speed_q <= '0;
					left_valid_q <= 1'b0;
					gate_count_q <= '0;
					mask_hit_q   <= 1'b0;
					mask_pos_q   <= '0;
					row_open_q   <= 1'b0;
				end else begin
					if (row_open_q) begin
						left_speed_q <= held_valid_q ? res : '0;
						left_valid_q <= held_valid_q;
					end
					held_speed_q <= spd;
					held_valid_q <= in_word.speed_valid;
					gate_count_q <= ci;
					mask_hit_q   <= hit_new;
					mask_pos_q   <= pos_new;
					row_open_q   <= 1'b1;
				end
			end
		end
	end

endmodule

// File: rtl/lrosm_outq.sv
// Result queue: takes up to two words per cycle, hands out one per cycle while out_stall is low.
// Depends on lrosm_pkg.
`timescale 1ns / 1ps

module lrosm_outq
	import lrosm_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    take,
	input  push_t   push,
	input  out_t    held_word,
	input  out_t    last_word,
	output logic    out_valid,
	input  logic    out_stall,
	output out_t    out_word,
	output q_stat_t stat
);

	out_t              mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	logic              pop;
	logic              wr0;
	logic              wr1;
	logic [QPTR_W-1:0] wr1_ptr;
	logic [QCNT_W-1:0] after_pop;
	logic [QCNT_W-1:0] n_push;

	always_comb begin
		out_valid = (count_q != '0);
		out_word  = mem_q[rd_ptr_q];
		pop       = out_valid && !out_stall;
		after_pop = count_q - QCNT_W'(pop);
		// an accepted gate may push two words
		stat.room  = (after_pop <= QCNT_W'(QDEPTH - 2));
		stat.count = count_q;
		wr0     = take && push.push_held;
		wr1     = take && push.push_last;
		wr1_ptr = wr_ptr_q + QPTR_W'(wr0);
		n_push  = QCNT_W'(wr0) + QCNT_W'(wr1);
	end

	always_ff @(posedge clk) begin
		if (wr0) begin
			mem_q[wr_ptr_q] <= held_word;
		end
		if (wr1) begin
			mem_q[wr1_ptr] <= last_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + n_push[QPTR_W-1:0];
			rd_ptr_q <= rd_ptr_q + QPTR_W'(pop);
			count_q  <= after_pop + n_push;
		end
	end

endmodule

// File: rtl/lidar_row_outlier_repair_snr_mask.sv
// Lidar row outlier repair with SNR mask, top level.
// Latency: a released word is on out_valid in the cycle after the taking edge when the queue
// is empty; a row's last gate is queued behind its held neighbor in the same take, and every other gate
// is released when the next gate of its row is taken.
// Throughput: one gate per cycle; in_stall rises only while fewer than two of the four queue
// slots would be free. Reset clears all row state and the queue and loads the register resets.
`timescale 1ns / 1ps

module lidar_row_outlier_repair_snr_mask
	import lrosm_pkg::*;
#(
	parameter int MAX_GATES = 64
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  in_t                  in_word,
	output logic                 out_valid,
	input  logic                 out_stall,
	output out_t                 out_word,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	logic    take;
	push_t   push;
	out_t    held_word;
	out_t    last_word;
	q_stat_t stat;

	assign in_stall = !stat.room;
	assign take     = in_valid && stat.room;

	lrosm_core #(
		.MAX_GATES(MAX_GATES)
	) u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.take     (take),
		.in_word  (in_word),
		.push     (push),
		.held_word(held_word),
		.last_word(last_word)
	);

	lrosm_outq u_outq (
		.clk      (clk),
		.arst_n   (arst_n),
		.take     (take),
		.push     (push),
		.held_word(held_word),
		.last_word(last_word),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_word (out_word),
		.stat     (stat)
	);

	a_q_bound: assert property (@(posedge clk) disable iff (!arst_n)
		stat.count <= QCNT_W'(QDEPTH))
		else $error("result queue over depth");

	a_empty_room: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> !in_stall)
		else $error("stall with empty result queue");

	a_row_end_out: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && in_word.row_end) |=> out_valid)
		else $error("row end gave no result word");

endmodule

// File: verif/tb_top.sv
// Testbench for lidar_row_outlier_repair_snr_mask: directed rows, then random rows under
// random stalls on both sides, each result word checked against a gate-by-gate predictor.
// Depends on rtl/lrosm_pkg.sv and the top level of the block.
`timescale 1ns / 1ps

module tb_top;
	import lrosm_pkg::*;

	localparam int TB_GATES = 64;
	localparam int GATE_CAP = (TB_GATES - 1 > 63) ? 63 : TB_GATES - 1;
	localparam int LIMIT    = 200000;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_stall;
	in_t                  in_word;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	out_t                 out_word;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;

	int idle_pct = 32;
	int errors   = 0;
	int cycles   = 0;
	int gates_sent = 0;

	// predictor copy of configuration and row state
	logic [THR_W-1:0]          thr_level  = THRESHOLD_RESET;
	logic signed [SNR_W-1:0]   mask_level = SNR_LEVEL_RESET;
	logic signed [SPEED_W-1:0] held_speed = '0;
	logic                      held_valid = 1'b0;
	logic signed [SPEED_W-1:0] left_speed = '0;
	logic                      left_valid = 1'b0;
	logic [GATE_W-1:0]         gate_count = '0;
	logic                      mask_hit   = 1'b0;
	logic [GATE_W-1:0]         mask_pos   = '0;
	logic                      row_open   = 1'b0;

	out_t gates_due[$];

	lidar_row_outlier_repair_snr_mask #(.MAX_GATES(TB_GATES)) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_word   (in_word),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_word  (out_word),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= LIMIT) begin
			$display("tb_top failed");
			$finish;
		end
	end

	always @(posedge clk) begin
		out_stall <= (idle_pct != 0) && ($urandom_range(99) < idle_pct);
	end

	// works out the words released by one accepted gate
	task automatic repair_gate(input in_t w);
		logic signed [SPEED_W-1:0] spd;
		logic signed [SPEED_W-1:0] res;
		logic [GATE_W-1:0]         ci;
		out_t                      r;
		int                        sum;
		int                        avg;
		int                        dev;
		spd = w.speed_valid ? w.speed_sample : '0;
		ci = '0;
		if (row_open)
			ci = (gate_count >= GATE_CAP) ? GATE_CAP[GATE_W-1:0] : gate_count + 1'b1;
		if (w.snr_valid && $signed(w.snr_sample) < mask_level && !mask_hit) begin
			mask_hit = 1'b1;
			mask_pos = ci;
		end
		if (row_open) begin
			res = held_speed;
			if (gate_count != 0 && held_valid && left_valid && w.speed_valid) begin
				sum = left_speed + spd;
				avg = sum >>> 1;
				dev = int'(held_speed) - avg;
				if (dev < 0)
					dev = -dev;
				if (dev > int'(thr_level))
					res = avg[SPEED_W-1:0];
			end
			r.speed_out       = held_valid ? res : '0;
			r.speed_out_valid = held_valid;
			r.gate_index      = gate_count;
			r.row_done        = 1'b0;
			r.mask_found      = 1'b0;
			r.mask_gate       = '0;
			gates_due = {gates_due, r};
			left_speed = held_valid ? res : '0;
			left_valid = held_valid;
		end
		if (w.row_end) begin
			r.speed_out       = spd;
			r.speed_out_valid = w.speed_valid;
			r.gate_index      = ci;
			r.row_done        = 1'b1;
			r.mask_found      = mask_hit;
			r.mask_gate       = mask_hit ? mask_pos : '0;
			gates_due = {gates_due, r};
			held_speed = '0;
			held_valid = 1'b0;
			left_speed = '0;
			left_valid = 1'b0;
			gate_count = '0;
			mask_hit   = 1'b0;
			mask_pos   = '0;
			row_open   = 1'b0;
		end else begin
			held_speed = spd;
			held_valid = w.speed_valid;
			gate_count = ci;
			row_open   = 1'b1;
		end
	endtask

	function automatic void cmp_field(input string name, input logic [31:0] e,
			input logic [31:0] a);
		if (e !== a) begin
			$display("%0t mismatch %s expected %0h actual %0h", $time, name, e, a);
			errors++;
		end
	endfunction

	always @(posedge clk) begin
		out_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (gates_due.size() == 0) begin
				$display("%0t unexpected word expected none actual %0h", $time, out_word);
				errors++;
			end else begin
				e = gates_due.pop_front();
				cmp_field("speed_out", e.speed_out, out_word.speed_out);
				cmp_field("speed_out_valid", e.speed_out_valid, out_word.speed_out_valid);
				cmp_field("gate_index", e.gate_index, out_word.gate_index);
				cmp_field("row_done", e.row_done, out_word.row_done);
				cmp_field("mask_found", e.mask_found, out_word.mask_found);
				cmp_field("mask_gate", e.mask_gate, out_word.mask_gate);
			end
		end
	end

	// called at a rising edge; returns at the edge where the gate is taken
	task automatic send_gate(input in_t w);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_word  <= w;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
		gates_sent++;
		repair_gate(w);
	endtask

	task automatic gate(input int spd, input bit sv, input int snr, input bit nv,
			input bit last);
		in_t w;
		w.speed_sample = spd[SPEED_W-1:0];
		w.speed_valid  = sv;
		w.snr_sample   = snr[SNR_W-1:0];
		w.snr_valid    = nv;
		w.row_end      = last;
		send_gate(w);
	endtask

	task automatic wait_drain();
		in_valid <= 1'b0;
		while (gates_due.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		if (idx == CFG_THRESHOLD)
			thr_level = val[THR_W-1:0];
		else
			mask_level = val[SNR_W-1:0];
	endtask

	task automatic set_config(input int thr, input int level);
		logic [CFG_W-SNR_W-1:0] junk;
		junk = $urandom;
		wait_drain();
		write_reg(CFG_THRESHOLD, thr[THR_W-1:0]);
		write_reg(CFG_SNR_LEVEL, {junk, level[SNR_W-1:0]});
	endtask

	task automatic send_random_row(input int len);
		in_t w;
		int  base;
		int  spd;
		int  snr;
		base = $urandom_range(4000) - 2000;
		for (int k = 0; k < len; k++) begin
			case ($urandom_range(9))
				0:       spd = $urandom;
				1, 2:    spd = base + $urandom_range(8000) - 4000;
				default: spd = base + $urandom_range(200) - 100;
			endcase
			if ($urandom_range(5) == 0)
				snr = $urandom;
			else
				snr = int'(mask_level) + $urandom_range(2100) - 100;
			w.speed_sample = spd[SPEED_W-1:0];
			w.speed_valid  = ($urandom_range(9) != 0);
			w.snr_sample   = snr[SNR_W-1:0];
			w.snr_valid    = ($urandom_range(7) != 0);
			w.row_end      = (k == len - 1);
			send_gate(w);
		end
	endtask

	task automatic send_random_rows(input int n_gates);
		int stop;
		stop = gates_sent + n_gates;
		while (gates_sent < stop)
			send_random_row(($urandom_range(19) == 0) ? $urandom_range(60, 80)
				: $urandom_range(1, 10));
	endtask

	// reset values: a lone spike is pulled to the neighbor average, negative SNR masked
	task automatic test_reset_config();
		gate(100, 1, 500, 1, 0);
		gate(0, 1, 300, 1, 0);
		gate(2000, 1, -5, 1, 0);
		gate(-1, 1, -300, 1, 0);
		gate(0, 1, 10, 1, 1);
	endtask

	task automatic test_extremes();
		set_config(0, -32768);
		gate(8388607, 1, 32767, 1, 0);
		gate(-8388608, 1, -32768, 1, 0);
		gate(8388607, 1, 0, 1, 0);
		gate(0, 1, -1, 1, 0);
		gate(-8388608, 1, 1, 1, 1);
		set_config(8388607, 32767);
		gate(-8388608, 1, 32767, 1, 0);
		gate(8388607, 1, 32767, 1, 0);
		gate(-8388608, 1, -32768, 1, 0);
		gate(8388607, 1, 32766, 1, 1);
	endtask

	// missing speed blocks repair around it; missing SNR never masks
	task automatic test_missing_samples();
		set_config(10, 0);
		gate(0, 1, -900, 0, 0);
		gate(5000, 1, 100, 1, 0);
		gate(-7000, 0, 100, 1, 0);
		gate(5000, 1, -4, 0, 0);
		gate(0, 0, -7, 1, 1);
	endtask

	task automatic test_short_rows();
		gate(30000, 1, -50, 1, 1);
		gate(-30000, 1, 50, 1, 0);
		gate(9999, 0, -50, 1, 1);
	endtask

	task automatic test_long_rows();
		set_config(1280, 0);
		send_random_row(70);
		send_random_row(64);
		send_random_row(63);
	endtask

	// sender holds off mid-row until every released word is out
	task automatic test_sender_hold();
		gate(10, 1, 20, 1, 0);
		gate(3000, 1, 20, 1, 0);
		gate(20, 1, -20, 1, 0);
		wait_drain();
		gate(-3000, 1, 20, 1, 0);
		gate(30, 1, 20, 1, 1);
	endtask

	task automatic test_back_to_back();
		set_config($urandom_range(2000), $urandom_range(400) - 200);
		idle_pct = 0;
		send_random_rows(100);
		idle_pct = 32;
	endtask

	task automatic test_random_phases();
		int thr;
		int level;
		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: thr = 1280;
				1: thr = 0;
				2: thr = 8388607;
				3: thr = $urandom_range(3000);
				4: thr = $urandom_range(8388607);
				default: thr = $urandom_range(500);
			endcase
			case (ph)
				1: level = -32768;
				2: level = 32767;
				4: level = $urandom;
				default: level = $urandom_range(2000) - 1000;
			endcase
			set_config(thr, level);
			send_random_rows(65);
		end
	endtask

	initial begin
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		in_word   = '0;
		cfg_we    = 1'b0;
		cfg_index = '0;
		cfg_data  = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_config();
		test_extremes();
		test_missing_samples();
		test_short_rows();
		test_sender_hold();
		test_long_rows();
		test_back_to_back();
		test_random_phases();
		wait_drain();
		repeat (16) @(posedge clk);
		if (errors == 0 && gates_due.size() == 0)
			$display("tb_top passed");
		else
			$display("tb_top failed");
		$finish;
	end

endmodule
